[design/npap_pkg.sv]
// ----------------------------------------------------------------------------
// npap_pkg
// Shared types and constants for the nested protobuf audio parser.
// ----------------------------------------------------------------------------
package npap_pkg;

  // Default payload limit in bytes
  localparam int MAX_PAYLOAD_DEF = 4096;

  // Protobuf wire types that the parser understands
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_LEN    = 3'd2;

  // Last varint byte index (ten bytes at most)
  localparam logic [3:0] VARINT_LAST = 4'd9;

  // Largest accepted codec mode
  localparam logic [63:0] MODE_MAX = 64'd8;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VARINT  = 3'd1,
    ST_BAD_WIRE    = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_BAD_MODE    = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_MISSING     = 3'd6,
    ST_TOO_LONG    = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_KEY  = 5'b00001,
    PH_VAL  = 5'b00010,
    PH_LEN  = 5'b00100,
    PH_SKIP = 5'b01000,
    PH_DONE = 5'b10000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  codec_mode;
    logic [11:0] encoded_offset;
    logic [12:0] encoded_length;
  } npap_result_t;

endpackage

[design/npap_core.sv]
// ----------------------------------------------------------------------------
// npap_core
// Per-byte protobuf wire-format state update and end-of-payload verdict.
// ----------------------------------------------------------------------------
module npap_core #(
  parameter int MAX_PAYLOAD = npap_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output npap_pkg::npap_result_t result
);
  import npap_pkg::*;

  localparam int POS_W = $clog2(MAX_PAYLOAD + 3);
  localparam int END_W = $clog2(2 * MAX_PAYLOAD + 2);

  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PAYLOAD);
  localparam logic [POS_W-1:0] POS_SAT  = POS_W'(MAX_PAYLOAD + 1);
  localparam logic [63:0]      LEN_LIM  = 64'(MAX_PAYLOAD);

  // State
  phase_t             phase,        phase_next;
  logic [1:0]         nest,         nest_next;
  logic [63:0]        accum,        accum_next;
  logic [3:0]         shift,        shift_next;
  logic [POS_W-1:0]   pos,          pos_next;
  logic [END_W-1:0]   mend0,        mend0_next;
  logic [END_W-1:0]   mend1,        mend1_next;
  logic               fn_one,       fn_one_next;
  logic               fn_two,       fn_two_next;
  logic [POS_W-1:0]   skip,         skip_next;
  logic               mode_seen,    mode_seen_next;
  logic               enc_seen,     enc_seen_next;
  logic [3:0]         held_mode,    held_mode_next;
  logic [POS_W-1:0]   held_off,     held_off_next;
  logic [POS_W-1:0]   held_len,     held_len_next;
  status_t            outcome,      outcome_next;

  // Working values
  logic [POS_W-1:0]   np;
  logic [END_W-1:0]   np_e;
  logic [3:0]         k;
  logic [63:0]        v;
  logic               at_end;
  logic [2:0]         wk;
  logic [END_W-1:0]   avail;
  logic [POS_W-1:0]   n;
  logic               len_bad;
  status_t            st;

  function automatic status_t close_code(input logic [1:0] lvl, input logic ok);
    if (lvl == 2'd1) begin
      return ST_NOT_FOUND;
    end
    return ok ? ST_OK : ST_MISSING;
  endfunction

  always_comb begin
    phase_next     = phase;
    nest_next      = nest;
    accum_next     = accum;
    shift_next     = shift;
    mend0_next     = mend0;
    mend1_next     = mend1;
    fn_one_next    = fn_one;
    fn_two_next    = fn_two;
    skip_next      = skip;
    mode_seen_next = mode_seen;
    enc_seen_next  = enc_seen;
    held_mode_next = held_mode;
    held_off_next  = held_off;
    held_len_next  = held_len;
    outcome_next   = outcome;
    avail          = '0;
    n              = '0;
    len_bad        = 1'b0;

    np       = pos + 1'b1;
    np_e     = END_W'(np);
    pos_next = (np > POS_SAT) ? POS_SAT : np;
    k        = (shift > VARINT_LAST) ? VARINT_LAST : shift;
    v        = accum | (64'(data_byte[6:0]) << ({2'b00, k} * 6'd7));
    wk       = v[2:0];
    at_end   = (nest == 2'd1 && np_e == mend0) || (nest == 2'd2 && np_e == mend1);

    if (phase != PH_DONE && pos < POS_MAX) begin
      if (phase == PH_SKIP) begin
        skip_next = skip - 1'b1;
        if (skip_next == '0) begin
          if (at_end) begin
            phase_next   = PH_DONE;
            outcome_next = close_code(nest, mode_seen && enc_seen && held_len != '0);
          end else begin
            phase_next = PH_KEY;
          end
        end
      end else begin
        accum_next = v;
        if (data_byte[7]) begin
          // continuation: fail on the tenth byte or at the message end
          if (k == VARINT_LAST || at_end) begin
            phase_next   = PH_DONE;
            outcome_next = ST_BAD_VARINT;
          end else begin
            shift_next = k + 1'b1;
          end
        end else begin
          accum_next = '0;
          shift_next = '0;
          unique case (phase)
            PH_KEY: begin
              fn_one_next = (v[34:3] == 32'd1);
              fn_two_next = (v[34:3] == 32'd2);
              if (wk != WT_VARINT && wk != WT_LEN) begin
                phase_next   = PH_DONE;
                outcome_next = ST_BAD_WIRE;
              end else if (at_end) begin
                phase_next   = PH_DONE;
                outcome_next = ST_BAD_VARINT;
              end else begin
                phase_next = (wk == WT_VARINT) ? PH_VAL : PH_LEN;
              end
            end
            PH_VAL: begin
              if (nest == 2'd2 && fn_one && v > MODE_MAX) begin
                phase_next   = PH_DONE;
                outcome_next = ST_BAD_MODE;
              end else begin
                if (nest == 2'd2 && fn_one) begin
                  held_mode_next = v[3:0];
                  mode_seen_next = 1'b1;
                end
                if (at_end) begin
                  phase_next   = PH_DONE;
                  outcome_next = close_code(nest,
                                   mode_seen_next && enc_seen && held_len != '0);
                end else begin
                  phase_next = PH_KEY;
                end
              end
            end
            PH_LEN: begin
              if (nest == 2'd0) begin
                n = (v > LEN_LIM) ? POS_SAT : v[POS_W-1:0];
              end else begin
                avail = ((nest == 2'd1) ? mend0 : mend1) - np_e;
                if (v > 64'(avail)) begin
                  len_bad = 1'b1;
                end else begin
                  n = v[POS_W-1:0];
                end
              end
              if (len_bad) begin
                phase_next   = PH_DONE;
                outcome_next = ST_OVERRUN;
              end else if (nest != 2'd2 && fn_one) begin
                // descend into the embedded message
                if (nest == 2'd0) begin
                  mend0_next = np_e + END_W'(n);
                end else begin
                  mend1_next = np_e + END_W'(n);
                end
                nest_next = nest + 1'b1;
                if (n == '0) begin
                  phase_next   = PH_DONE;
                  outcome_next = close_code(nest_next,
                                   mode_seen && enc_seen && held_len != '0);
                end else begin
                  phase_next = PH_KEY;
                end
              end else begin
                if (nest == 2'd2 && fn_two) begin
                  held_off_next = np;
                  held_len_next = n;
                  enc_seen_next = 1'b1;
                end
                skip_next = n;
                if (n != '0) begin
                  phase_next = PH_SKIP;
                end else if (at_end) begin
                  phase_next   = PH_DONE;
                  outcome_next = close_code(nest,
                                   mode_seen && enc_seen_next && held_len_next != '0);
                end else begin
                  phase_next = PH_KEY;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end

    // Verdict from the updated state
    if (np > POS_MAX) begin
      st = ST_TOO_LONG;
    end else if (nest_next != 2'd0 && mend0_next > np_e) begin
      st = ST_OVERRUN;
    end else if (phase_next == PH_DONE) begin
      st = outcome_next;
    end else if (phase_next == PH_SKIP) begin
      st = ST_OVERRUN;
    end else if (phase_next == PH_KEY && shift_next == '0) begin
      st = ST_NOT_FOUND;
    end else begin
      st = ST_BAD_VARINT;
    end

    result        = '0;
    result.status = st;
    if (st == ST_OK) begin
      result.codec_mode     = held_mode_next;
      result.encoded_offset = 12'(held_off_next);
      result.encoded_length = 13'(held_len_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      phase     <= PH_KEY;
      nest      <= '0;
      accum     <= '0;
      shift     <= '0;
      pos       <= '0;
      mend0     <= '0;
      mend1     <= '0;
      fn_one    <= 1'b0;
      fn_two    <= 1'b0;
      skip      <= '0;
      mode_seen <= 1'b0;
      enc_seen  <= 1'b0;
      held_mode <= '0;
      held_off  <= '0;
      held_len  <= '0;
      outcome   <= ST_OK;
    end else if (step) begin
      phase     <= phase_next;
      nest      <= nest_next;
      accum     <= accum_next;
      shift     <= shift_next;
      pos       <= pos_next;
      mend0     <= mend0_next;
      mend1     <= mend1_next;
      fn_one    <= fn_one_next;
      fn_two    <= fn_two_next;
      skip      <= skip_next;
      mode_seen <= mode_seen_next;
      enc_seen  <= enc_seen_next;
      held_mode <= held_mode_next;
      held_off  <= held_off_next;
      held_len  <= held_len_next;
      outcome   <= outcome_next;
    end
  end

endmodule

[design/nested_protobuf_audio_parser.sv]
// ----------------------------------------------------------------------------
// nested_protobuf_audio_parser
// Streams a protobuf payload byte by byte and reports the codec mode and the
// location of the encoded audio inside the nested codec message.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] data_byte, s_tlast last_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata status, codec_mode, offset, length
//
//  One byte a cycle while no verdict is stalled: an accepted byte is parsed out
//  of the input register and the parser state advances as it leaves there, so
//  a request may enter every cycle.
//  A verdict lands in the result register at the edge on which its last byte
//  leaves the input register; a stalled verdict holds the next last byte there
//  and the bytes behind it wait, while earlier bytes are still parsed.
//  Synchronous reset clears the parser to the start of a payload; each last
//  byte also returns it there, ready for the next payload.
// ----------------------------------------------------------------------------
module nested_protobuf_audio_parser #(
  parameter int MAX_PAYLOAD = npap_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [2:0] status, [6:3] codec_mode,
                                 // [18:7] encoded_offset, [31:19] encoded_length
);
  import npap_pkg::*;

  // Input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  logic         advance;
  npap_result_t result;

  // Parse the held byte unless it closes a payload whose verdict cannot land
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  npap_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .last_byte (in_last),
    .result    (result)
  );

  // Result register: load on a parsed last byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {result.encoded_length, result.encoded_offset,
                  result.codec_mode, result.status};
    end
  end

endmodule

[design/npap_checker.sv]
// ----------------------------------------------------------------------------
// npap_checker
// Port-level checks for the nested protobuf audio parser.
// ----------------------------------------------------------------------------
module npap_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import npap_pkg::*;

  // Hold a stalled verdict
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("verdict changed while stalled");

  // Failed verdicts carry no mode, offset or length
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[31:3] == '0)
    else $error("failed verdict carries payload fields");

  // Good verdicts carry a legal mode and a nonempty encoded run
  a_ok_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == ST_OK |-> m_tdata[6:3] <= 4'd8 && m_tdata[31:19] != '0)
    else $error("good verdict with bad mode or empty audio");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("verdict present after reset");

endmodule

bind nested_protobuf_audio_parser npap_checker u_npap_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
